### sv/thhtc_pkg.sv
// Package for the thermal head heat time calculator.
// Holds register codes, reset values, widths, the configuration struct and
// the reciprocal constants of the heat time division. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package thhtc_pkg;

    localparam int BYTES_PER_GROUP_DEF = 8;
    localparam int STROBE_GROUPS_DEF   = 6;
    localparam int NUM_OFFSETS         = 6;
    localparam int GRP_W               = 3;
    localparam int BYTE_W              = 8;
    localparam int BASE_W              = 16;
    localparam int DENS_W              = 8;
    localparam int OFFS_W              = 16;
    localparam int CFG_IDX_W           = 3;
    localparam int HEAT_W              = 18;
    localparam int OUT_TDATA_W         = 24;
    localparam int QUEUE_DEPTH         = 4;

    // Base plus offset, then scaled sum, then magnitude and products.
    localparam int SO_W  = 18;
    localparam int NUM_W = 28;
    localparam int MAG_W = 27;
    localparam int P_W   = MAG_W + DENS_W;
    localparam int DIV_SHIFT = 5;
    localparam int X_W   = P_W - DIV_SHIFT;
    localparam int DIV_K = 42;
    localparam longint DIV_ODD = 3125;
    localparam longint DIV_MUL_L = ((64'sd1 <<< DIV_K) + DIV_ODD - 1) / DIV_ODD;
    localparam int M_W   = 31;
    localparam logic [M_W-1:0] DIV_MUL = M_W'(DIV_MUL_L);
    localparam int PROD_W = X_W + M_W;
    localparam int Q_W    = PROD_W - DIV_K;
    localparam logic [HEAT_W-1:0] HEAT_MAX = '1;
    localparam logic signed [NUM_W-1:0] US_SCALE = NUM_W'(1000);

    localparam logic [CFG_IDX_W-1:0] REG_BASE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DENSITY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET0 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET2 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET3 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET4 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET5 = 3'd7;

    localparam logic [BASE_W-1:0] BASE_RST    = 16'd2000;
    localparam logic [DENS_W-1:0] DENSITY_RST = 8'd100;
    localparam logic [OFFS_W-1:0] OFFSET0_RST = 16'd1000;

    typedef struct packed {
        logic [BASE_W-1:0]                   base;
        logic [DENS_W-1:0]                   density;
        logic [NUM_OFFSETS-1:0][OFFS_W-1:0]  offset;
    } t_cfg;

endpackage
`default_nettype wire

### sv/thhtc_front.sv
// Front part of the heat time calculator: takes line bytes, sums each
// strobe group and hands finished groups to the queue. Uses thhtc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module thhtc_front #(
    parameter int BYTES_PER_GROUP = thhtc_pkg::BYTES_PER_GROUP_DEF,
    parameter int STROBE_GROUPS   = thhtc_pkg::STROBE_GROUPS_DEF,
    parameter int SUM_W           = $clog2(255 * BYTES_PER_GROUP + 1)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire logic [thhtc_pkg::BYTE_W-1:0]  i_byte,
    input  wire logic                          i_queue_full,
    output logic                               o_ready,
    output logic                               o_push,
    output logic [thhtc_pkg::GRP_W-1:0]        o_grp,
    output logic                               o_last,
    output logic [SUM_W-1:0]                   o_sum
);

    localparam int CNT_W = $clog2(BYTES_PER_GROUP + 1);

    logic [CNT_W-1:0]                r_cnt, n_cnt;
    logic [thhtc_pkg::GRP_W-1:0]     r_grp, n_grp;
    logic [SUM_W-1:0]                r_sum, n_sum;
    logic [SUM_W-1:0]                sum_add;
    logic                            take, group_end, line_end;

    assign o_ready   = !i_queue_full;
    assign take      = i_valid && o_ready;
    assign sum_add   = r_sum + SUM_W'(i_byte);
    assign group_end = (r_cnt == CNT_W'(BYTES_PER_GROUP - 1));
    assign line_end  = (r_grp == thhtc_pkg::GRP_W'(STROBE_GROUPS - 1));

    assign o_push = take && group_end;
    assign o_grp  = r_grp;
    assign o_last = line_end;
    assign o_sum  = sum_add;

    always_comb begin
        n_cnt = r_cnt;
        n_grp = r_grp;
        n_sum = r_sum;
        if (take) begin
            if (group_end) begin
                n_cnt = '0;
                n_sum = '0;
                n_grp = line_end ? '0 : r_grp + 1'b1;
            end else begin
                n_cnt = r_cnt + 1'b1;
                n_sum = sum_add;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_grp <= '0;
            r_sum <= '0;
        end else begin
            r_cnt <= n_cnt;
            r_grp <= n_grp;
            r_sum <= n_sum;
        end
    end

endmodule
`default_nettype wire

### sv/thhtc_queue.sv
// Short first-in first-out queue between the front and back parts.
// Holds finished groups; uses thhtc_pkg for its default depth.
`timescale 1ns / 1ps
`default_nettype none
module thhtc_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = thhtc_pkg::QUEUE_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty,
    output logic                  o_full
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

### sv/thhtc_back.sv
// Back part of the heat time calculator: a stalling pipeline that squares
// the group sum, applies base, offset and density, and divides by 100000.
// Uses thhtc_pkg; fed by thhtc_queue.
`timescale 1ns / 1ps
`default_nettype none
module thhtc_back #(
    parameter int SUM_W = 11
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire thhtc_pkg::t_cfg                   i_cfg,
    input  wire logic                              i_q_empty,
    input  wire logic [thhtc_pkg::GRP_W-1:0]       i_grp,
    input  wire logic                              i_last,
    input  wire logic [SUM_W-1:0]                  i_sum,
    output logic                                   o_pop,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic [thhtc_pkg::GRP_W-1:0]            o_grp,
    output logic [thhtc_pkg::HEAT_W-1:0]           o_heat,
    output logic                                   o_last
);

    localparam int SQ_W = 2 * SUM_W;

    logic adv;

    logic                                   r_v1, r_v2, r_v3, r_v4, r_vo;
    logic [thhtc_pkg::GRP_W-1:0]            r_g1, r_g2, r_g3, r_g4, r_go;
    logic                                   r_l1, r_l2, r_l3, r_l4, r_lo;
    logic signed [thhtc_pkg::SO_W-1:0]      r_so;
    logic [SQ_W-1:0]                        r_sq;
    logic [thhtc_pkg::MAG_W-1:0]            r_mag;
    logic [thhtc_pkg::X_W-1:0]              r_x;
    logic [thhtc_pkg::Q_W-1:0]              r_q;
    logic [thhtc_pkg::HEAT_W-1:0]           r_heat;

    logic signed [thhtc_pkg::OFFS_W-1:0]    off;
    logic signed [thhtc_pkg::SO_W-1:0]      so_sum;
    logic signed [thhtc_pkg::NUM_W-1:0]     num;
    logic [thhtc_pkg::P_W-1:0]              prod_d;
    logic [thhtc_pkg::PROD_W-1:0]           prod_m;

    assign adv   = !r_vo || i_ready;
    assign o_pop = adv && !i_q_empty;

    always_comb begin
        if (i_grp < thhtc_pkg::GRP_W'(thhtc_pkg::NUM_OFFSETS)) begin
            off = $signed(i_cfg.offset[i_grp]);
        end else begin
            off = '0;
        end
    end

    assign so_sum = $signed({2'b00, i_cfg.base})
                  + $signed({{(thhtc_pkg::SO_W - thhtc_pkg::OFFS_W){off[thhtc_pkg::OFFS_W-1]}},
                             off});

    assign num = $signed({{(thhtc_pkg::NUM_W - thhtc_pkg::SO_W){r_so[thhtc_pkg::SO_W-1]}}, r_so})
               * thhtc_pkg::US_SCALE
               + $signed({{(thhtc_pkg::NUM_W - SQ_W){1'b0}}, r_sq});

    assign prod_d = thhtc_pkg::P_W'(r_mag) * thhtc_pkg::P_W'(i_cfg.density);
    assign prod_m = thhtc_pkg::PROD_W'(r_x) * thhtc_pkg::PROD_W'(thhtc_pkg::DIV_MUL);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_so  <= so_sum;
            r_sq  <= SQ_W'(i_sum) * SQ_W'(i_sum);
            r_mag <= (num > 0) ? num[thhtc_pkg::MAG_W-1:0] : '0;
            r_x   <= prod_d[thhtc_pkg::P_W-1:thhtc_pkg::DIV_SHIFT];
            r_q   <= prod_m[thhtc_pkg::PROD_W-1:thhtc_pkg::DIV_K];
            r_heat <= r_q[thhtc_pkg::Q_W-1] ? thhtc_pkg::HEAT_MAX
                                            : r_q[thhtc_pkg::HEAT_W-1:0];
            r_g1 <= i_grp;
            r_l1 <= i_last;
            r_g2 <= r_g1;
            r_l2 <= r_l1;
            r_g3 <= r_g2;
            r_l3 <= r_l2;
            r_g4 <= r_g3;
            r_l4 <= r_l3;
            r_go <= r_g4;
            r_lo <= r_l4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_vo <= 1'b0;
        end else if (adv) begin
            r_v1 <= !i_q_empty;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_vo <= r_v4;
        end
    end

    assign o_valid = r_vo;
    assign o_grp   = r_go;
    assign o_heat  = r_heat;
    assign o_last  = r_lo;

endmodule
`default_nettype wire

### sv/thermal_head_heat_time_calc_unit.sv
// Top level of the thermal head heat time calculator: configuration
// registers, front, queue and back. Uses thhtc_pkg and the thhtc_* modules.
//
//  Channel   Direction  Payload (lowest bit first)              Handshake
//  s_axis    in         tdata[7:0] line_byte                    tvalid/tready
//  m_axis    out        tdata[2:0] group_index, [20:3] heat_us  tvalid/tready
//                       tlast line_done
//  cfg       in         index 0..7, data 16 bits                write enable
//
// One line byte is taken each cycle while tready is high. A heat time passes
// from the queue through the five-stage multiply and divide pipeline to the
// output. A stalled output holds the pipeline, the queue then fills and tready
// drops. Reset is synchronous and returns the configuration registers to
// their default values.
`timescale 1ns / 1ps
`default_nettype none
module thermal_head_heat_time_calc_unit #(
    parameter int BYTES_PER_GROUP = thhtc_pkg::BYTES_PER_GROUP_DEF,
    parameter int STROBE_GROUPS   = thhtc_pkg::STROBE_GROUPS_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_s_axis_tvalid,
    output logic                                      o_s_axis_tready,
    input  wire logic [thhtc_pkg::BYTE_W-1:0]         i_s_axis_tdata,   // line_byte
    output logic                                      o_m_axis_tvalid,
    input  wire logic                                 i_m_axis_tready,
    output logic [thhtc_pkg::OUT_TDATA_W-1:0]         o_m_axis_tdata,   // group_index, heat_time_us
    output logic                                      o_m_axis_tlast,
    input  wire logic                                 i_cfg_we,
    input  wire logic [thhtc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [thhtc_pkg::OFFS_W-1:0]         i_cfg_data
);

    localparam int SUM_W = $clog2(255 * BYTES_PER_GROUP + 1);
    localparam int Q_DW  = thhtc_pkg::GRP_W + 1 + SUM_W;

    thhtc_pkg::t_cfg r_cfg;

    logic                          push, pop, q_empty, q_full;
    logic [thhtc_pkg::GRP_W-1:0]   f_grp, b_grp, o_grp;
    logic                          f_last, b_last;
    logic [SUM_W-1:0]              f_sum, b_sum;
    logic [Q_DW-1:0]               q_out;
    logic [thhtc_pkg::HEAT_W-1:0]  o_heat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base    <= thhtc_pkg::BASE_RST;
            r_cfg.density <= thhtc_pkg::DENSITY_RST;
            r_cfg.offset  <= {{((thhtc_pkg::NUM_OFFSETS - 1) * thhtc_pkg::OFFS_W){1'b0}},
                              thhtc_pkg::OFFSET0_RST};
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                thhtc_pkg::REG_BASE:    r_cfg.base      <= i_cfg_data;
                thhtc_pkg::REG_DENSITY: r_cfg.density   <= i_cfg_data[thhtc_pkg::DENS_W-1:0];
                thhtc_pkg::REG_OFFSET0: r_cfg.offset[0] <= i_cfg_data;
                thhtc_pkg::REG_OFFSET1: r_cfg.offset[1] <= i_cfg_data;
                thhtc_pkg::REG_OFFSET2: r_cfg.offset[2] <= i_cfg_data;
                thhtc_pkg::REG_OFFSET3: r_cfg.offset[3] <= i_cfg_data;
                thhtc_pkg::REG_OFFSET4: r_cfg.offset[4] <= i_cfg_data;
                thhtc_pkg::REG_OFFSET5: r_cfg.offset[5] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    thhtc_front #(
        .BYTES_PER_GROUP (BYTES_PER_GROUP),
        .STROBE_GROUPS   (STROBE_GROUPS),
        .SUM_W           (SUM_W)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_axis_tvalid),
        .i_byte       (i_s_axis_tdata),
        .i_queue_full (q_full),
        .o_ready      (o_s_axis_tready),
        .o_push       (push),
        .o_grp        (f_grp),
        .o_last       (f_last),
        .o_sum        (f_sum)
    );

    thhtc_queue #(
        .WIDTH (Q_DW),
        .DEPTH (thhtc_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_grp, f_last, f_sum}),
        .i_pop   (pop),
        .o_data  (q_out),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    assign {b_grp, b_last, b_sum} = q_out;

    thhtc_back #(
        .SUM_W (SUM_W)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_empty (q_empty),
        .i_grp     (b_grp),
        .i_last    (b_last),
        .i_sum     (b_sum),
        .o_pop     (pop),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_grp     (o_grp),
        .o_heat    (o_heat),
        .o_last    (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {3'b000, o_heat, o_grp};

endmodule
`default_nettype wire

### sv/thhtc_checker.sv
// Port checker for the heat time calculator, bound to the top level.
// Depends on thermal_head_heat_time_calc_unit and thhtc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module thhtc_checker #(
    parameter int STROBE_GROUPS = thhtc_pkg::STROBE_GROUPS_DEF
) (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                o_m_axis_tvalid,
    input wire logic                                i_m_axis_tready,
    input wire logic [thhtc_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,
    input wire logic                                o_m_axis_tlast
);

    localparam logic [thhtc_pkg::GRP_W-1:0] LAST_GRP =
        thhtc_pkg::GRP_W'(STROBE_GROUPS - 1);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output request valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("stalled output request changed");

    a_grp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[2:0] <= LAST_GRP)
        else $error("group index out of range");

    a_last_grp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tlast == (o_m_axis_tdata[2:0] == LAST_GRP)))
        else $error("line end flag does not match the last group");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[23:21] == 3'b000)
        else $error("output padding bits not zero");

endmodule

bind thermal_head_heat_time_calc_unit thhtc_checker #(
    .STROBE_GROUPS (STROBE_GROUPS)
) u_thhtc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
`default_nettype wire

### sim/tb.sv
// Testbench for the thermal head heat time calculator. It streams line bytes,
// predicts each strobe group's heat time and checks every result in order.
// Depends on thhtc_pkg and thermal_head_heat_time_calc_unit.
`timescale 1ns / 1ps
module tb;
    import thhtc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 16;
    localparam int PHASES = 9;
    localparam int PRESSURE_PHASE = 4;
    localparam int HOLD_CYCLES = 400;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    class heat_scoreboard;
        typedef struct packed {
            logic [GRP_W-1:0]  group_index;
            logic [HEAT_W-1:0] heat_us;
            logic              line_done;
        } heat_result_t;

        logic [BASE_W-1:0]        base_us;
        logic [DENS_W-1:0]        density;
        logic signed [OFFS_W-1:0] offset_us [NUM_OFFSETS];
        int unsigned              byte_cnt;
        int unsigned              cur_group;
        int unsigned              group_sum;
        heat_result_t             pending [$];
        int                       errors;

        function new();
            base_us = BASE_RST;
            density = DENSITY_RST;
            foreach (offset_us[i]) offset_us[i] = '0;
            offset_us[0] = OFFSET0_RST;
            byte_cnt = 0;
            cur_group = 0;
            group_sum = 0;
            errors = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [OFFS_W-1:0] val);
            case (idx)
                REG_BASE: base_us = val;
                REG_DENSITY: density = val[DENS_W-1:0];
                default: offset_us[idx - REG_OFFSET0] = val;
            endcase
        endfunction

        function logic [HEAT_W-1:0] heat_for(int unsigned g, int unsigned s);
            longint num;
            longint q;
            num = longint'(base_us) * 1000 + longint'(s) * longint'(s)
                  + longint'(offset_us[g]) * 1000;
            if (num <= 0) return '0;
            q = num * longint'(density) / 100000;
            if (q > longint'(HEAT_MAX)) return HEAT_MAX;
            return q[HEAT_W-1:0];
        endfunction

        function void note_byte(logic [BYTE_W-1:0] b);
            heat_result_t r;
            group_sum += b;
            byte_cnt++;
            if (byte_cnt == BYTES_PER_GROUP_DEF) begin
                r.group_index = cur_group[GRP_W-1:0];
                r.heat_us = heat_for(cur_group, group_sum);
                r.line_done = (cur_group == STROBE_GROUPS_DEF - 1);
                pending.push_back(r);
                byte_cnt = 0;
                group_sum = 0;
                cur_group = r.line_done ? 0 : cur_group + 1;
            end
        endfunction

        task report(string msg);
            errors++;
            $display("tb: mismatch at %0t: %s", $realtime, msg);
        endtask

        task check_result(logic [OUT_TDATA_W-1:0] data, logic last);
            heat_result_t want;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result group %0d heat %0d",
                                 data[GRP_W-1:0], data[GRP_W +: HEAT_W]));
                return;
            end
            want = pending.pop_front();
            if (data[GRP_W-1:0] !== want.group_index)
                report($sformatf("group_index %0d, expected %0d",
                                 data[GRP_W-1:0], want.group_index));
            if (data[GRP_W +: HEAT_W] !== want.heat_us)
                report($sformatf("group %0d heat_time_us %0d, expected %0d",
                                 want.group_index, data[GRP_W +: HEAT_W], want.heat_us));
            if (last !== want.line_done)
                report($sformatf("group %0d line_done %0b, expected %0b",
                                 want.group_index, last, want.line_done));
        endtask
    endclass

    logic                   i_clk;
    logic                   rst_n = 1'b0;
    logic                   s_valid = 1'b0;
    logic [BYTE_W-1:0]      s_data = '0;
    logic                   s_ready;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_data;
    logic                   m_last;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [OFFS_W-1:0]      cfg_data = '0;

    idle_mode_t     idle_mode = IDLE_NONE;
    logic           hold_req = 1'b0;
    logic           hold_done = 1'b0;
    int             hold_left = 0;
    int             cycles = 0;
    heat_scoreboard sb = new();

    thermal_head_heat_time_calc_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tlast  (m_last),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Result side: check accepted results, then pick the next ready level.
    always @(posedge i_clk) begin
        int stall_pct;
        stall_pct = (idle_mode == IDLE_RECV) ? 48 : (idle_mode == IDLE_BOTH) ? 6 : 0;
        if (rst_n && m_valid && m_ready)
            sb.check_result(m_data, m_last);
        if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            m_ready <= 1'b0;
            hold_left <= HOLD_CYCLES - 1;
        end else if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    function automatic logic [BYTE_W-1:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return BYTE_W'($urandom);
        endcase
    endfunction

    task send_byte(logic [BYTE_W-1:0] b);
        int gap_pct;
        gap_pct = (idle_mode == IDLE_SEND) ? 48 : (idle_mode == IDLE_BOTH) ? 6 : 0;
        while ($urandom_range(0, 99) < gap_pct) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data <= b;
        do @(posedge i_clk); while (!s_ready);
        sb.note_byte(b);
    endtask

    task wait_drained();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task write_reg(logic [CFG_IDX_W-1:0] idx, logic [OFFS_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        sb.set_reg(idx, val);
    endtask

    task program_config(int p);
        logic [BASE_W-1:0] base_v;
        logic [DENS_W-1:0] dens_v;
        logic [OFFS_W-1:0] off_v [NUM_OFFSETS];
        case (p)
            0: begin
                base_v = '1;
                dens_v = '1;
                foreach (off_v[i]) off_v[i] = 16'h7FFF;
            end
            1: begin
                base_v = '0;
                dens_v = '1;
                foreach (off_v[i]) off_v[i] = 16'h8000;
            end
            2: begin
                base_v = BASE_W'($urandom);
                dens_v = '0;
                foreach (off_v[i]) off_v[i] = OFFS_W'($urandom);
            end
            3: begin
                base_v = 16'd1;
                dens_v = 8'd1;
                foreach (off_v[i]) off_v[i] = '0;
            end
            default: begin
                base_v = $urandom_range(0, 1) ? BASE_W'($urandom_range(0, 4000))
                                               : BASE_W'($urandom);
                dens_v = DENS_W'($urandom);
                foreach (off_v[i])
                    off_v[i] = $urandom_range(0, 1) ? OFFS_W'($urandom_range(0, 6000) - 3000)
                                                     : OFFS_W'($urandom);
            end
        endcase
        write_reg(REG_BASE, base_v);
        write_reg(REG_DENSITY, {BASE_W'($urandom)} << DENS_W | dens_v);
        write_reg(REG_OFFSET0, off_v[0]);
        write_reg(REG_OFFSET1, off_v[1]);
        write_reg(REG_OFFSET2, off_v[2]);
        write_reg(REG_OFFSET3, off_v[3]);
        write_reg(REG_OFFSET4, off_v[4]);
        write_reg(REG_OFFSET5, off_v[5]);
        cfg_we <= 1'b0;
    endtask

    initial begin
        int n;
        repeat (12) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // Full-scale group, empty group, then alternating bit patterns.
        repeat (BYTES_PER_GROUP_DEF) send_byte(8'hFF);
        repeat (BYTES_PER_GROUP_DEF) send_byte(8'h00);
        repeat (BYTES_PER_GROUP_DEF / 2) begin
            send_byte(8'h55);
            send_byte(8'hAA);
        end
        s_valid <= 1'b0;

        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            program_config(p);
            idle_mode = idle_mode_t'(p % 4);
            n = $urandom_range(36, 44);
            if (p == PRESSURE_PHASE) begin
                hold_req = 1'b1;
                n = 96;
            end
            repeat (n) send_byte(pick_byte());
            s_valid <= 1'b0;
        end

        idle_mode = IDLE_NONE;
        wait_drained();
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
